@@ src/complementary_tilt_filter_assert.svh @@
// Assertion macros used by the bound checker module.
`ifndef COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define COMPLEMENTARY_TILT_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CTF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tilt filter assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tilt filter assertion failed");

`endif

@@ src/ctf_pkg.sv @@
`timescale 1ns / 1ps
package ctf_pkg;

  localparam int TILT_W   = 25;
  localparam int ANG_W    = 26;
  localparam int STEP_W   = 5;
  localparam int ATAN_LEN = 24;
  localparam int WEIGHT_W = 16;
  localparam int GAIN_W   = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 1;
  localparam int OPB_W    = GAIN_W + 1;
  localparam int WT_W     = WEIGHT_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP_GAIN = 1'b1;

  localparam logic [WEIGHT_W-1:0] BLEND_RESET = 16'd64225;
  localparam logic [GAIN_W-1:0]   GAIN_RESET  = 24'd327861;
  localparam logic [WT_W-1:0]     W_ONE       = 17'd65536;

  localparam logic signed [ANG_W-1:0]  ANG_90   = 26'sd5898240;
  localparam logic signed [ANG_W-1:0]  ANG_MAX  = 26'sd11796480;
  localparam logic signed [ANG_W-1:0]  ANG_MIN  = -ANG_MAX;
  localparam logic signed [TILT_W-1:0] TILT_MAX = 25'sd11796480;
  localparam logic signed [TILT_W-1:0] TILT_MIN = -TILT_MAX;

  // atan(2^-i) in degrees, Q8.16
  localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    26'd2949120, 26'd1740967, 26'd919879, 26'd466945, 26'd234379, 26'd117304,
    26'd58666,   26'd29335,   26'd14668,  26'd7334,   26'd3667,   26'd1833,
    26'd917,     26'd458,     26'd229,    26'd115,    26'd57,     26'd29,
    26'd14,      26'd7,       26'd4,      26'd2,      26'd1,      26'd0
  };

  typedef enum logic [1:0] {
    MUL_GYRO,
    MUL_ACCEL,
    MUL_INNER
  } mul_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL_ACCEL,
    ST_MUL_INNER,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic              load;
    logic              rot;
    logic [STEP_W-1:0] step;
    logic              prod_en;
    mul_sel_t          mul_sel;
    logic              inner_en;
    logic              part_en;
    logic              finish;
  } ctf_cmd_t;

endpackage

@@ src/ctf_ctrl.sv @@
`timescale 1ns / 1ps
module ctf_ctrl import ctf_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ctf_cmd_t cmd
);

  localparam int STEPS_USED = (CORDIC_STEPS < 2) ? 2 :
                              ((CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_USED - 1);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;
  logic              slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_ROT;
      ST_ROT:       if (step == LAST_STEP) state_next = ST_MUL_ACCEL;
      ST_MUL_ACCEL: state_next = ST_MUL_INNER;
      ST_MUL_INNER: state_next = ST_SUM;
      ST_SUM:       if (slot_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.step = step;
    cmd.mul_sel = MUL_GYRO;
    case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_ROT: begin
        cmd.rot = 1'b1;
        // gyro product and its sum with the estimate run alongside the rotations
        if (step == '0) begin
          cmd.prod_en = 1'b1;
          cmd.mul_sel = MUL_GYRO;
        end
        if (step == STEP_W'(1)) cmd.inner_en = 1'b1;
      end
      ST_MUL_ACCEL: begin
        cmd.prod_en = 1'b1;
        cmd.mul_sel = MUL_ACCEL;
      end
      ST_MUL_INNER: begin
        cmd.prod_en = 1'b1;
        cmd.mul_sel = MUL_INNER;
        cmd.part_en = 1'b1;
      end
      ST_SUM:  cmd.finish = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    step_next = (state == ST_ROT) ? step + STEP_W'(1) : '0;
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (cmd.finish) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ src/ctf_datapath.sv @@
`timescale 1ns / 1ps
module ctf_datapath import ctf_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ctf_cmd_t                      cmd,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  input  logic signed [SAMPLE_BITS-1:0] gyro_y,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  output logic signed [TILT_W-1:0]      tilt_angle
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = SB + 11;                               // CORDIC vector
  localparam int IW = ((SB + 10 > TILT_W) ? SB + 10 : TILT_W) + 2; // inner sum
  localparam int MA = IW;                                    // multiplier operand a
  localparam int PW = MA + OPB_W;                            // product
  localparam int QW = PW - 15;
  localparam logic signed [PW:0]   ROUND = (PW+1)'(32768);
  localparam logic signed [QW-1:0] Q_MAX = QW'(TILT_MAX);
  localparam logic signed [QW-1:0] Q_MIN = -Q_MAX;

  logic [WEIGHT_W-1:0]      blend_w;
  logic [GAIN_W-1:0]        gain;
  logic signed [CW-1:0]     x, y, x_next, y_next, xs, ys;
  logic signed [ANG_W-1:0]  ang, ang_next;
  logic                     zero;
  logic signed [SB-1:0]     gyro_reg;
  logic signed [SB:0]       gneg;
  logic signed [MA-1:0]     op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PW-1:0]     prod, part, prod_full;
  logic signed [IW-1:0]     inner, inner_next;
  logic signed [PW:0]       inc_sum, mix_sum;
  logic signed [QW-1:0]     mix_q;
  logic signed [TILT_W-1:0] est, est_next, accel;
  logic signed [CW-1:0]     ax_s, az_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_w <= BLEND_RESET;
      gain    <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_WEIGHT:   blend_w <= cfg_data[WEIGHT_W-1:0];
        REG_GYRO_STEP_GAIN: gain    <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // inputs scaled by 256 into the CORDIC width
  assign ax_s = {{3{accel_x[SB-1]}}, accel_x, 8'b0};
  assign az_s = {{3{accel_z[SB-1]}}, accel_z, 8'b0};
  assign xs   = x >>> cmd.step;
  assign ys   = y >>> cmd.step;

  always_comb begin
    x_next   = x;
    y_next   = y;
    ang_next = ang;
    if (cmd.load) begin
      x_next   = az_s;
      y_next   = ax_s;
      ang_next = '0;
      // quarter-turn pre-rotation into the right half plane
      if (az_s[CW-1]) begin
        if (!ax_s[CW-1]) begin
          x_next   = ax_s;
          y_next   = -az_s;
          ang_next = ANG_90;
        end else begin
          x_next   = -ax_s;
          y_next   = az_s;
          ang_next = -ANG_90;
        end
      end
    end else if (cmd.rot) begin
      if (!y[CW-1]) begin
        x_next   = x + ys;
        y_next   = y - xs;
        ang_next = ang + ATAN_TAB[cmd.step];
      end else begin
        x_next   = x - ys;
        y_next   = y + xs;
        ang_next = ang - ATAN_TAB[cmd.step];
      end
    end
  end

  always_ff @(posedge clk) begin
    x   <= x_next;
    y   <= y_next;
    ang <= ang_next;
    if (cmd.load) begin
      zero     <= (accel_x == '0) && (accel_z == '0);
      gyro_reg <= gyro_y;
    end
  end

  always_comb begin
    if (zero)
      accel = '0;
    else if (ang > ANG_MAX)
      accel = TILT_MAX;
    else if (ang < ANG_MIN)
      accel = TILT_MIN;
    else
      accel = ang[TILT_W-1:0];
  end

  assign gneg = -{gyro_reg[SB-1], gyro_reg};

  // one shared multiplier: gyro increment, then both blend terms
  always_comb begin
    case (cmd.mul_sel)
      MUL_GYRO: begin
        op_a = {{(MA-SB-1){gneg[SB]}}, gneg};
        op_b = {1'b0, gain};
      end
      MUL_ACCEL: begin
        op_a = {{(MA-TILT_W){accel[TILT_W-1]}}, accel};
        op_b = {{(OPB_W-WT_W){1'b0}}, W_ONE - {1'b0, blend_w}};
      end
      MUL_INNER: begin
        op_a = inner;
        op_b = {{(OPB_W-WEIGHT_W){1'b0}}, blend_w};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_full  = op_a * op_b;
  assign inc_sum    = {prod[PW-1], prod} + ROUND;
  assign inner_next = {{(IW-TILT_W){est[TILT_W-1]}}, est} + inc_sum[IW+15:16];
  assign mix_sum    = {part[PW-1], part} + {prod[PW-1], prod} + ROUND;
  assign mix_q      = mix_sum[PW:16];

  always_comb begin
    if (mix_q > Q_MAX)
      est_next = TILT_MAX;
    else if (mix_q < Q_MIN)
      est_next = TILT_MIN;
    else
      est_next = mix_q[TILT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_en)  prod  <= prod_full;
    if (cmd.part_en)  part  <= prod;
    if (cmd.inner_en) inner <= inner_next;
    if (cmd.finish)   tilt_angle <= est_next;
  end

  always_ff @(posedge clk) begin
    if (rst)
      est <= '0;
    else if (cmd.finish)
      est <= est_next;
  end

endmodule

@@ src/complementary_tilt_filter.sv @@
`timescale 1ns / 1ps
// Channel   Signals                           Transfer when
// ------    -------                           -------------
// in        in_valid, in_stall, accel_x,      in_valid && !in_stall
//           accel_z, gyro_y
// out       out_valid, out_stall, tilt_angle  out_valid && !out_stall
// cfg       cfg_we, cfg_index, cfg_data       cfg_we
//
// After transfer in, an item passes through the CORDIC rotations, the two blend products
// and the final sum before its result is valid. The gyro product and its sum with the
// estimate overlap the rotations.
// The next item is taken the cycle after the result is loaded into the output register;
// the input stalls while an item is in progress.
// A held result only delays completion of the following item, not its intake.
// rst is synchronous: estimate goes to zero degrees and registers to their defaults.
module complementary_tilt_filter import ctf_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  input  logic signed [SAMPLE_BITS-1:0] gyro_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [TILT_W-1:0]      tilt_angle,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  ctf_cmd_t cmd;

  ctf_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ctf_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .accel_x    (accel_x),
    .accel_z    (accel_z),
    .gyro_y     (gyro_y),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tilt_angle (tilt_angle)
  );

endmodule

@@ src/ctf_checker.sv @@
`timescale 1ns / 1ps
`include "complementary_tilt_filter_assert.svh"
module ctf_checker import ctf_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [TILT_W-1:0] tilt_angle
);

  `CTF_ASSERT_NOW(a_tilt_range, clk, rst, out_valid, (tilt_angle <= TILT_MAX) && (tilt_angle >= TILT_MIN))
  `CTF_ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && !in_stall, in_stall)
  `CTF_ASSERT_NOW(a_result_frees_input, clk, rst, $rose(out_valid), !in_stall)
  `CTF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(tilt_angle))

endmodule

bind complementary_tilt_filter ctf_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .tilt_angle (tilt_angle)
);

@@ tb/ctf_tilt_checker.sv @@
`timescale 1ns / 1ps
module ctf_tilt_checker import ctf_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  input  logic signed [SAMPLE_BITS-1:0] gyro_y,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [TILT_W-1:0]      tilt_angle,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            compared,
  output int                            saturated
);

  logic [WEIGHT_W-1:0]       weight_q;
  logic [GAIN_W-1:0]         gain_q;
  longint                    tilt_q;
  logic signed [TILT_W-1:0]  tilt_due [$];
  int                        errors;
  int                        checked;
  int                        sat_seen;

  assign fail_count = errors;
  assign compared   = checked;
  assign saturated  = sat_seen;

  function automatic longint clamp180(longint v);
    if (v > longint'(ANG_MAX)) return longint'(ANG_MAX);
    if (v < longint'(ANG_MIN)) return longint'(ANG_MIN);
    return v;
  endfunction

  // atan2(y, x) in Q8.16 degrees by vectoring CORDIC
  function automatic longint accel_angle(longint y, longint x);
    longint ang;
    longint t;
    longint xs;
    longint ys;
    int     steps;
    int     i;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 256;
    y = y * 256;
    // quarter-turn pre-rotation into the right half plane
    if (x < 0) begin
      if (y >= 0) begin
        t   = x;
        x   = y;
        y   = -t;
        ang = longint'(ANG_90);
      end else begin
        t   = x;
        x   = -y;
        y   = t;
        ang = -longint'(ANG_90);
      end
    end
    steps = CORDIC_STEPS;
    if (steps < 1) steps = 1;
    if (steps > ATAN_LEN) steps = ATAN_LEN;
    for (i = 0; i < steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        ang = ang + longint'(ATAN_TAB[i]);
      end else begin
        x   = x - ys;
        y   = y + xs;
        ang = ang - longint'(ATAN_TAB[i]);
      end
    end
    return clamp180(ang);
  endfunction

  function automatic longint blend_tilt(longint est, longint ax, longint az, longint gy,
                                        longint w, longint gain);
    longint acc;
    longint inc;
    longint mix;
    acc = accel_angle(ax, az);
    inc = (-gy * gain + 32768) >>> 16;
    mix = (65536 - w) * acc + w * (est + inc);
    return clamp180((mix + 32768) >>> 16);
  endfunction

  task automatic flag_error(input string msg);
    if (errors < 40) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    longint                   next_tilt;
    logic signed [TILT_W-1:0] due;
    if (rst) begin
      tilt_q   <= 0;
      weight_q <= BLEND_RESET;
      gain_q   <= GAIN_RESET;
      tilt_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BLEND_WEIGHT:   weight_q <= cfg_data[WEIGHT_W-1:0];
          REG_GYRO_STEP_GAIN: gain_q   <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (tilt_due.size() == 0) begin
          flag_error($sformatf("tilt result %0d with no sample outstanding", tilt_angle));
        end else begin
          due = tilt_due.pop_front();
          checked++;
          if (due == TILT_MAX || due == TILT_MIN) sat_seen++;
          if (tilt_angle !== due)
            flag_error($sformatf("tilt_angle %0d, expected %0d", tilt_angle, due));
        end
      end
      if (in_valid && !in_stall) begin
        next_tilt = blend_tilt(tilt_q, longint'(accel_x), longint'(accel_z),
                               longint'(gyro_y), longint'(weight_q), longint'(gain_q));
        tilt_q <= next_tilt;
        tilt_due.push_back(next_tilt[TILT_W-1:0]);
      end
    end
    pending <= tilt_due.size();
  end

endmodule

@@ tb/tb_complementary_tilt_filter.sv @@
`timescale 1ns / 1ps
module tb_complementary_tilt_filter;
  import ctf_pkg::*;

  localparam int CORDIC_STEPS   = 16;
  localparam int SAMPLE_BITS    = 16;
  localparam int SETTLE_CYCLES  = CORDIC_STEPS + 14;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int BURST_LEN      = 200;
  localparam int N_BURSTS       = 8;
  localparam int N_FIXED        = 6;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  logic signed [SAMPLE_BITS-1:0] gyro_y;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [TILT_W-1:0]      tilt_angle;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_W-1:0]              cfg_data;

  int fail_count;
  int pending;
  int compared;
  int saturated;
  int samples_sent;
  int settings_used;
  int quiet_cycles;
  bit steady_sender;

  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          stall_left = 0;
  int          stall_roll;

  // settings visited by the fixed bursts; the rest are random
  logic [WEIGHT_W-1:0] burst_weight [N_FIXED] = '{
    16'd0, 16'd65535, 16'd65535, 16'd0, 16'd32768, BLEND_RESET
  };
  logic [GAIN_W-1:0]   burst_gain   [N_FIXED] = '{
    24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd65536, GAIN_RESET
  };

  complementary_tilt_filter #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .accel_x   (accel_x),
    .accel_z   (accel_z),
    .gyro_y    (gyro_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tilt_angle(tilt_angle),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ctf_tilt_checker #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .accel_x   (accel_x),
    .accel_z   (accel_z),
    .gyro_y    (gyro_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tilt_angle(tilt_angle),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending),
    .compared  (compared),
    .saturated (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result-side back-pressure; the mode drifts so quiet stretches occur too
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(2));
      mode_left  <= 200 + $urandom_range(300);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      stall_roll = $urandom_range(99);
      case (stall_mode)
        STALL_LIGHT: begin
          out_stall <= (stall_roll < 20);
          if (stall_roll < 20) stall_left <= $urandom_range(2);
        end
        STALL_HEAVY: begin
          out_stall <= (stall_roll < 40);
          if (stall_roll < 8) stall_left <= 20 + $urandom_range(60);
          else if (stall_roll < 40) stall_left <= $urandom_range(3);
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("complementary_tilt_filter test failed");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] ax,
                             input logic signed [SAMPLE_BITS-1:0] az,
                             input logic signed [SAMPLE_BITS-1:0] gy);
    int gap;
    int roll;
    accel_x  <= ax;
    accel_z  <= az;
    gyro_y   <= gy;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    roll = $urandom_range(99);
    if (steady_sender || roll < 55) gap = 0;
    else if (roll < 90) gap = 1 + $urandom_range(3);
    else gap = 20 + $urandom_range(40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every outstanding result, then let the datapath go quiet
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [WEIGHT_W-1:0] weight, input logic [GAIN_W-1:0] gain);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BLEND_WEIGHT;
    // upper bits of the weight write are don't-care
    cfg_data  <= {8'($urandom), weight};
    @(posedge clk);
    cfg_index <= REG_GYRO_STEP_GAIN;
    cfg_data  <= gain;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] corner_value();
    case ($urandom_range(4))
      0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2:       return '1;
      3:       return 1;
      default: return 0;
    endcase
  endfunction

  task automatic run_burst(input int count);
    logic signed [SAMPLE_BITS-1:0] ax;
    logic signed [SAMPLE_BITS-1:0] az;
    logic signed [SAMPLE_BITS-1:0] gy;
    int kind;
    steady_sender = ($urandom_range(3) == 0);
    repeat (count) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // gravity-sized accel, modest rotation rate
        ax = SAMPLE_BITS'(int'($urandom_range(34000)) - 17000);
        az = SAMPLE_BITS'(int'($urandom_range(34000)) - 17000);
        gy = SAMPLE_BITS'(int'($urandom_range(4000)) - 2000);
      end else if (kind < 65) begin
        ax = SAMPLE_BITS'($urandom);
        az = SAMPLE_BITS'($urandom);
        gy = SAMPLE_BITS'($urandom);
      end else if (kind < 80) begin
        // tiny vectors, zeros and sign corners of the pre-rotation
        ax = SAMPLE_BITS'(int'($urandom_range(8)) - 4);
        az = SAMPLE_BITS'(int'($urandom_range(8)) - 4);
        gy = SAMPLE_BITS'($urandom);
      end else if (kind < 90) begin
        ax = corner_value();
        az = corner_value();
        gy = corner_value();
      end else begin
        // one accel axis zero
        ax = SAMPLE_BITS'($urandom);
        az = SAMPLE_BITS'($urandom);
        if ($urandom_range(1)) ax = 0;
        else az = 0;
        gy = SAMPLE_BITS'(int'($urandom_range(600)) - 300);
      end
      send_sample(ax, az, gy);
    end
  endtask

  initial begin
    int p;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    accel_x       <= '0;
    accel_z       <= '0;
    gyro_y        <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_BLEND_WEIGHT;
    cfg_data      <= '0;
    samples_sent  = 0;
    settings_used = 1;
    steady_sender = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, accel corners and special angles
    send_sample(0, 0, 0);
    send_sample(0, -1, 0);
    send_sample(0, -32768, 0);
    send_sample(0, 32767, 0);
    send_sample(32767, 0, 0);
    send_sample(-32768, 0, 0);
    send_sample(32767, -32768, 0);
    send_sample(-32768, -32768, 0);
    send_sample(-1, -32768, 0);
    send_sample(1, -32768, 0);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, 32767, -32768);
    send_sample(0, 0, 32767);
    send_sample(0, 0, -32768);
    send_sample(-1, -1, -1);
    send_sample(16384, 0, 131);
    drain();

    // full gyro weight and gain: drive the estimate into both limits
    set_config(16'd65535, 24'hFFFFFF);
    repeat (3) send_sample(0, 0, -32768);
    repeat (3) send_sample(0, 0, 32767);
    drain();

    for (p = 0; p < N_BURSTS; p++) begin
      if (p < N_FIXED) begin
        set_config(burst_weight[p], burst_gain[p]);
      end else begin
        set_config(16'($urandom),
                   $urandom_range(1) ? 24'($urandom_range(1 << 20)) : 24'($urandom));
      end
      run_burst(BURST_LEN);
      drain();
    end

    $display("run covered %0d samples over %0d weight/gain settings", samples_sent,
             settings_used);
    $display("%0d tilt results compared, %0d at the +/-180 degree limit, %0d mismatches",
             compared, saturated, fail_count);
    if (fail_count == 0) begin
      $display("complementary_tilt_filter test passed");
    end else begin
      $display("complementary_tilt_filter test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/ctf_pkg.sv
src/ctf_ctrl.sv
src/ctf_datapath.sv
src/complementary_tilt_filter.sv
src/ctf_checker.sv
tb/ctf_tilt_checker.sv
tb/tb_complementary_tilt_filter.sv
